[sv/atok_pkg.sv]
// ----------------------------------------------------------------------------
// atok_pkg
// shared types and codes for the argument tokenizer with escape decoding
// ----------------------------------------------------------------------------
package atok_pkg;

  // result kinds
  localparam logic [2:0] KIND_BYTE    = 3'd0;
  localparam logic [2:0] KIND_ARGEND  = 3'd1;
  localparam logic [2:0] KIND_LINEEND = 3'd2;
  localparam logic [2:0] KIND_BADESC  = 3'd3;
  localparam logic [2:0] KIND_NOQUOTE = 3'd4;

  // parser phases
  localparam logic [2:0] PH_BETWEEN = 3'd0;
  localparam logic [2:0] PH_ARG     = 3'd1;
  localparam logic [2:0] PH_ESC     = 3'd2;
  localparam logic [2:0] PH_OCT     = 3'd3;
  localparam logic [2:0] PH_HEX1    = 3'd4;
  localparam logic [2:0] PH_HEX2    = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;

  // configuration register indexes
  localparam logic CFG_COMMENT = 1'b0;
  localparam logic CFG_COMMA   = 1'b1;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LFX   = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_X     = 8'h78;

  // results one byte can cause, and the result queue
  localparam int MAX_RES    = 3;
  localparam int RES_CNT_W  = 2;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       quoted;
    logic [7:0] esc;
    logic [1:0] digits;
  } pstate_t;

  typedef struct packed {
    logic comment_en;
    logic comma_en;
  } cfg_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               room;
  } fifo_status_t;

endpackage

[sv/argv_tokenizer_with_escapes_unit.sv]
// ----------------------------------------------------------------------------
// argv_tokenizer_with_escapes_unit
// splits a zero-terminated line into arguments and decodes backslash escapes
// ----------------------------------------------------------------------------
//  port group  dir  handshake            payload
//  in_*        in   in_valid / in_stall   in_byte
//  out_*       out  out_valid / out_stall out_kind, out_byte, out_last
//  cfg_*       in   cfg_we               cfg_index, cfg_data
//
// one byte is taken per cycle unless the input stalls; it waits in the input
// register, then its zero to three results enter an eight-entry queue and leave
// one per beat, so the first result is offered once the byte has passed the
// input register and the queue, and leaves when the output is not stalled.
// a byte causing several results holds the output for that many beats; the
// input stalls while a waiting byte finds fewer than three free queue entries.
// reset clears the parser state, the configuration and the queue.
module argv_tokenizer_with_escapes_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data
);
  import atok_pkg::*;

  logic                         in_full;
  logic [7:0]                   byte_q;
  logic                         proc_fire;
  logic                         in_take;
  cfg_t                         cfg;
  pstate_t                      st;
  pstate_t                      st_next;
  result_t [MAX_RES-1:0]        res;
  logic [RES_CNT_W-1:0]         res_count;
  logic [RES_CNT_W-1:0]         push_count;
  result_t                      head;
  fifo_status_t                 fstat;
  logic                         pop;

  assign proc_fire  = in_full && fstat.room;
  assign in_stall   = in_full && !fstat.room;
  assign in_take    = in_valid && !in_stall;
  assign push_count = proc_fire ? res_count : '0;
  assign out_valid  = (fstat.count != '0);
  assign pop        = out_valid && !out_stall;
  assign out_kind   = head.kind;
  assign out_byte   = head.data;
  assign out_last   = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (proc_fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_q <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMMENT: cfg.comment_en <= cfg_data;
        CFG_COMMA:   cfg.comma_en   <= cfg_data;
        default:     cfg            <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase  <= PH_BETWEEN;
      st.quoted <= 1'b0;
      st.esc    <= 8'h00;
      st.digits <= 2'd0;
    end else if (proc_fire) begin
      st <= st_next;
    end
  end

  atok_parse u_parse (
    .cur       (st),
    .cfg       (cfg),
    .in_byte   (byte_q),
    .nxt       (st_next),
    .res       (res),
    .res_count (res_count)
  );

  atok_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_res   (res),
    .push_count (push_count),
    .pop        (pop),
    .head       (head),
    .status     (fstat)
  );

  // queue never overflows
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fstat.count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  // a zero byte always leaves the parser between arguments
  a_line_reset: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && byte_q == CH_NUL) |=> (st.phase == PH_BETWEEN && !st.quoted
      && st.esc == 8'h00 && st.digits == 2'd0))
    else $error("parser not reset by line end");

  // output valid only drops after a beat left
  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(pop))
    else $error("result lost from output");

  // a processed byte always reports at least one result when it ends a line
  a_line_result: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && byte_q == CH_NUL) |-> (res_count != '0))
    else $error("line end produced no result");

endmodule

[sv/atok_parse.sv]
// ----------------------------------------------------------------------------
// atok_parse
// one byte step of the tokenizer: next parser state and up to three results
// ----------------------------------------------------------------------------
module atok_parse (
  input  atok_pkg::pstate_t                    cur,
  input  atok_pkg::cfg_t                       cfg,
  input  logic [7:0]                           in_byte,
  output atok_pkg::pstate_t                    nxt,
  output atok_pkg::result_t [atok_pkg::MAX_RES-1:0] res,
  output logic [atok_pkg::RES_CNT_W-1:0]       res_count
);
  import atok_pkg::*;

  logic       is_space;
  logic       is_oct;
  logic       is_dec;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic [7:0] oct_acc;

  assign is_space = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);
  assign is_oct   = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
  assign is_dec   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign hex_ok   = is_dec || (in_byte >= CH_LA && in_byte <= CH_LFX)
                  || (in_byte >= CH_UA && in_byte <= CH_UF);
  // letters a-f and A-F both have low nibble 1..6
  assign hex_val  = is_dec ? in_byte[3:0] : in_byte[3:0] + 4'd9;
  assign oct_acc  = {cur.esc[4:0], in_byte[2:0]};

  always_comb begin
    logic [RES_CNT_W:0] n;
    logic               do_arg;
    logic               do_lineend;
    logic [2:0]         k  [MAX_RES];
    logic [7:0]         d  [MAX_RES];
    logic [2:0]         k1;
    logic [7:0]         d1;
    logic               e1;
    logic [2:0]         k2;
    logic [7:0]         d2;
    logic               e2;
    logic [2:0]         k3;
    logic               e3;
    logic [7:0]         esc_c;
    logic               esc_ok;

    nxt        = cur;
    n          = '0;
    do_arg     = 1'b0;
    do_lineend = 1'b0;
    k1 = KIND_BYTE; d1 = 8'h00; e1 = 1'b0;
    k2 = KIND_BYTE; d2 = 8'h00; e2 = 1'b0;
    k3 = KIND_LINEEND;          e3 = 1'b0;
    esc_c  = 8'h00;
    esc_ok = 1'b1;
    for (int i = 0; i < MAX_RES; i++) begin
      k[i] = KIND_BYTE;
      d[i] = 8'h00;
    end

    // first slot: result of the phase handler itself
    unique case (cur.phase)
      PH_ARG: begin
        do_arg = 1'b1;
      end
      PH_ESC: begin
        unique case (in_byte)
          CH_N:     esc_c = CH_LF;
          CH_R:     esc_c = CH_CR;
          CH_T:     esc_c = CH_TAB;
          CH_QUOTE: esc_c = CH_QUOTE;
          CH_BSL:   esc_c = CH_BSL;
          default:  esc_ok = 1'b0;
        endcase
        if (esc_ok) begin
          e1 = 1'b1; k1 = KIND_BYTE; d1 = esc_c;
          nxt.phase = PH_ARG;
        end else if (is_oct) begin
          nxt.esc    = {5'd0, in_byte[2:0]};
          nxt.digits = 2'd1;
          nxt.phase  = PH_OCT;
        end else if (in_byte == CH_X) begin
          nxt.esc   = 8'h00;
          nxt.phase = PH_HEX1;
        end else begin
          e1 = 1'b1; k1 = KIND_BADESC;
          nxt.esc    = 8'h00;
          nxt.digits = 2'd0;
          nxt.phase  = PH_SKIP;
          do_lineend = (in_byte == CH_NUL);
        end
      end
      PH_OCT: begin
        if (is_oct && cur.digits != 2'd3) begin
          if (cur.digits == 2'd2) begin
            e1 = 1'b1; k1 = KIND_BYTE; d1 = oct_acc;
            nxt.esc    = 8'h00;
            nxt.digits = 2'd0;
            nxt.phase  = PH_ARG;
          end else begin
            nxt.esc    = oct_acc;
            nxt.digits = cur.digits + 2'd1;
          end
        end else begin
          // flush the pending octal byte, then treat this one normally
          e1 = 1'b1; k1 = KIND_BYTE; d1 = cur.esc;
          nxt.esc    = 8'h00;
          nxt.digits = 2'd0;
          nxt.phase  = PH_ARG;
          do_arg     = 1'b1;
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (!hex_ok) begin
          e1 = 1'b1; k1 = KIND_BADESC;
          nxt.esc    = 8'h00;
          nxt.digits = 2'd0;
          nxt.phase  = PH_SKIP;
          do_lineend = (in_byte == CH_NUL);
        end else if (cur.phase == PH_HEX1) begin
          nxt.esc   = {4'd0, hex_val};
          nxt.phase = PH_HEX2;
        end else begin
          e1 = 1'b1; k1 = KIND_BYTE; d1 = {cur.esc[3:0], hex_val};
          nxt.esc   = 8'h00;
          nxt.phase = PH_ARG;
        end
      end
      PH_SKIP: begin
        do_lineend = (in_byte == CH_NUL);
      end
      default: begin
        if (in_byte == CH_NUL) begin
          do_lineend = 1'b1;
        end else if (is_space) begin
          nxt.phase = PH_BETWEEN;
        end else if (cfg.comment_en && in_byte == CH_HASH) begin
          nxt.phase = PH_SKIP;
        end else if (in_byte == CH_QUOTE) begin
          nxt.quoted = 1'b1;
          nxt.phase  = PH_ARG;
        end else begin
          nxt.quoted = 1'b0;
          nxt.phase  = PH_ARG;
          do_arg     = 1'b1;
        end
      end
    endcase

    // second slot: ordinary argument byte handling
    if (do_arg) begin
      if (in_byte == CH_BSL) begin
        nxt.phase = PH_ESC;
      end else if (!nxt.quoted) begin
        if (in_byte == CH_NUL) begin
          e2 = 1'b1; k2 = KIND_ARGEND;
          do_lineend = 1'b1;
        end else if (is_space || (cfg.comma_en && in_byte == CH_COMMA)) begin
          e2 = 1'b1; k2 = KIND_ARGEND;
          nxt.phase = PH_BETWEEN;
        end else begin
          e2 = 1'b1; k2 = KIND_BYTE; d2 = in_byte;
        end
      end else begin
        if (in_byte == CH_QUOTE) begin
          e2 = 1'b1; k2 = KIND_ARGEND;
          nxt.quoted = 1'b0;
          nxt.phase  = PH_BETWEEN;
        end else if (in_byte == CH_NUL) begin
          e2 = 1'b1; k2 = KIND_NOQUOTE;
          do_lineend = 1'b1;
        end else begin
          e2 = 1'b1; k2 = KIND_BYTE; d2 = in_byte;
        end
      end
    end

    // third slot: line end returns the parser to its reset state
    if (do_lineend) begin
      e3 = 1'b1;
      nxt.phase  = PH_BETWEEN;
      nxt.quoted = 1'b0;
      nxt.esc    = 8'h00;
      nxt.digits = 2'd0;
    end

    // pack the used slots in order
    if (e1) begin
      k[n[1:0]] = k1; d[n[1:0]] = d1; n = n + 3'd1;
    end
    if (e2) begin
      k[n[1:0]] = k2; d[n[1:0]] = d2; n = n + 3'd1;
    end
    if (e3 && n < 3'(MAX_RES)) begin
      k[n[1:0]] = k3; d[n[1:0]] = 8'h00; n = n + 3'd1;
    end

    res_count = n[RES_CNT_W-1:0];
    for (int i = 0; i < MAX_RES; i++) begin
      res[i].kind = k[i];
      res[i].data = d[i];
      res[i].last = (3'(i) + 3'd1 == n);
    end
  end

endmodule

[sv/atok_fifo.sv]
// ----------------------------------------------------------------------------
// atok_fifo
// result queue: takes up to three results per cycle, hands out one per beat
// ----------------------------------------------------------------------------
module atok_fifo (
  input  logic                                     clk,
  input  logic                                     rst,
  input  atok_pkg::result_t [atok_pkg::MAX_RES-1:0] push_res,
  input  logic [atok_pkg::RES_CNT_W-1:0]           push_count,
  input  logic                                     pop,
  output atok_pkg::result_t                        head,
  output atok_pkg::fifo_status_t                   status
);
  import atok_pkg::*;

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic [FIFO_CW-1:0]   count_next;

  assign count_next = count + FIFO_CW'(push_count) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_count);
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_CNT_W'(i) < push_count) begin
        mem[wr_ptr + FIFO_AW'(i)] <= push_res[i];
      end
    end
  end

  assign head         = mem[rd_ptr];
  assign status.count = count;
  // room for the worst case of one byte
  assign status.room  = (count <= FIFO_CW'(FIFO_DEPTH - MAX_RES));

endmodule

[verif/argv_tokenizer_with_escapes_unit_tb.sv]
// ----------------------------------------------------------------------------
// argv_tokenizer_with_escapes_unit_tb
// drives zero-terminated lines into the tokenizer, one byte per beat, and
// checks every result beat against a behavioral copy of the parser. covers
// escapes, quoting, comma and comment options under random idling and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module argv_tokenizer_with_escapes_unit_tb;
  import atok_pkg::*;

  localparam int RUN_LIMIT = 100000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_we;
  logic       cfg_index;
  logic       cfg_data;

  argv_tokenizer_with_escapes_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_byte(out_byte),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // parser copy and its options
  logic [2:0] tk_phase;
  logic       tk_quoted;
  logic [7:0] tk_esc;
  logic [1:0] tk_digits;
  logic       opt_comment;
  logic       opt_comma;

  result_t expected_tokens[$];
  result_t step_tokens[$];

  int  cycle;
  int  beats_in;
  int  errors;
  int  hold_until;
  bit  tx_idle_on;
  bit  rx_idle_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void add_token(logic [2:0] kind, logic [7:0] data);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.last = 1'b0;
    step_tokens.push_back(r);
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_LA && c <= CH_LFX) return c - CH_LA + 10;
    if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
    return -1;
  endfunction

  function automatic void line_finish();
    add_token(KIND_LINEEND, 8'h00);
    tk_phase = PH_BETWEEN;
    tk_quoted = 1'b0;
    tk_esc = 8'h00;
    tk_digits = 2'd0;
  endfunction

  function automatic void flag_bad_escape(logic [7:0] c);
    add_token(KIND_BADESC, 8'h00);
    tk_esc = 8'h00;
    tk_digits = 2'd0;
    if (c == CH_NUL) line_finish();
    else tk_phase = PH_SKIP;
  endfunction

  function automatic void arg_char(logic [7:0] c);
    if (c == CH_BSL) begin
      tk_phase = PH_ESC;
    end else if (!tk_quoted) begin
      if (c == CH_NUL) begin
        add_token(KIND_ARGEND, 8'h00);
        line_finish();
      end else if (is_blank(c) || (opt_comma && c == CH_COMMA)) begin
        add_token(KIND_ARGEND, 8'h00);
        tk_phase = PH_BETWEEN;
      end else begin
        add_token(KIND_BYTE, c);
      end
    end else if (c == CH_QUOTE) begin
      add_token(KIND_ARGEND, 8'h00);
      tk_quoted = 1'b0;
      tk_phase = PH_BETWEEN;
    end else if (c == CH_NUL) begin
      add_token(KIND_NOQUOTE, 8'h00);
      line_finish();
    end else begin
      add_token(KIND_BYTE, c);
    end
  endfunction

  function automatic void predict_tokens(logic [7:0] c);
    int         h;
    logic [7:0] dec;
    bit         simple;
    step_tokens.delete();
    case (tk_phase)
      PH_ARG: arg_char(c);
      PH_ESC: begin
        simple = 1'b1;
        dec = c;
        case (c)
          CH_N: dec = CH_LF;
          CH_R: dec = CH_CR;
          CH_T: dec = CH_TAB;
          CH_QUOTE, CH_BSL: dec = c;
          default: simple = 1'b0;
        endcase
        if (simple) begin
          add_token(KIND_BYTE, dec);
          tk_phase = PH_ARG;
        end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
          tk_esc = {5'd0, c[2:0]};
          tk_digits = 2'd1;
          tk_phase = PH_OCT;
        end else if (c == CH_X) begin
          tk_esc = 8'h00;
          tk_phase = PH_HEX1;
        end else begin
          flag_bad_escape(c);
        end
      end
      PH_OCT: begin
        if (c >= CH_ZERO && c <= CH_SEVEN && tk_digits < 2'd3) begin
          // value kept modulo 256
          tk_esc = {tk_esc[4:0], c[2:0]};
          tk_digits = tk_digits + 2'd1;
          if (tk_digits == 2'd3) begin
            add_token(KIND_BYTE, tk_esc);
            tk_esc = 8'h00;
            tk_digits = 2'd0;
            tk_phase = PH_ARG;
          end
        end else begin
          // flush the pending octal byte, then treat c as a plain arg byte
          add_token(KIND_BYTE, tk_esc);
          tk_esc = 8'h00;
          tk_digits = 2'd0;
          tk_phase = PH_ARG;
          arg_char(c);
        end
      end
      PH_HEX1: begin
        h = hex_value(c);
        if (h < 0) begin
          flag_bad_escape(c);
        end else begin
          tk_esc = 8'(h);
          tk_phase = PH_HEX2;
        end
      end
      PH_HEX2: begin
        h = hex_value(c);
        if (h < 0) begin
          flag_bad_escape(c);
        end else begin
          add_token(KIND_BYTE, {tk_esc[3:0], 4'(h)});
          tk_esc = 8'h00;
          tk_phase = PH_ARG;
        end
      end
      PH_SKIP: if (c == CH_NUL) line_finish();
      default: begin
        if (c == CH_NUL) begin
          line_finish();
        end else if (is_blank(c)) begin
          // separator only
        end else if (opt_comment && c == CH_HASH) begin
          tk_phase = PH_SKIP;
        end else if (c == CH_QUOTE) begin
          tk_quoted = 1'b1;
          tk_phase = PH_ARG;
        end else begin
          tk_quoted = 1'b0;
          tk_phase = PH_ARG;
          arg_char(c);
        end
      end
    endcase
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // --------------------------------------------------------------- monitors

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > RUN_LIMIT) begin
      $display("argv_tokenizer_with_escapes_unit_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_tokens(in_byte);
      beats_in <= beats_in + 1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0b",
                 $time, out_kind, out_byte, out_last);
        errors++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_kind);
          errors++;
        end
        if (out_byte !== want.data) begin
          $display("%0t: byte expected %02h actual %02h", $time, want.data, out_byte);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (cycle < hold_until) out_stall <= 1'b1;
    else if (rx_idle_on) out_stall <= ($urandom_range(0, 99) < 9);
    else out_stall <= 1'b0;
  end

  // ---------------------------------------------------------------- drivers

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(logic [7:0] c);
    int taken;
    taken = beats_in;
    in_valid <= 1'b1;
    in_byte <= c;
    do @(negedge clk); while (beats_in == taken);
    if (tx_idle_on && $urandom_range(0, 99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]));
    send_byte(CH_NUL);
  endtask

  // stop sending and wait until every result has come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_tokens.size() != 0);
    // a byte with no result may still sit in the input register
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COMMENT) opt_comment = val;
    else opt_comma = val;
  endtask

  function automatic logic [7:0] hex_char();
    case ($urandom_range(0, 2))
      0: return 8'(CH_ZERO + $urandom_range(0, 9));
      1: return 8'(CH_LA + $urandom_range(0, 5));
      default: return 8'(CH_UA + $urandom_range(0, 5));
    endcase
  endfunction

  // mostly well-formed arguments with random content, some noise
  task automatic send_random_line(inout int sent);
    logic [7:0] line[$];
    int         pick;
    int         k;
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        k = $urandom_range(0, 6);
        if (k == 6) line.push_back(CH_COMMA);
        else if (k == 5) line.push_back(CH_SPACE);
        else line.push_back(8'(CH_TAB + k));
      end else if (pick < 45) begin
        repeat ($urandom_range(1, 3)) line.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 55) begin
        line.push_back(CH_QUOTE);
      end else if (pick < 65) begin
        line.push_back(CH_BSL);
        case ($urandom_range(0, 4))
          0: line.push_back(CH_N);
          1: line.push_back(CH_R);
          2: line.push_back(CH_T);
          3: line.push_back(CH_QUOTE);
          default: line.push_back(CH_BSL);
        endcase
      end else if (pick < 75) begin
        line.push_back(CH_BSL);
        repeat ($urandom_range(1, 3)) line.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
      end else if (pick < 85) begin
        line.push_back(CH_BSL);
        line.push_back(CH_X);
        line.push_back(hex_char());
        line.push_back(hex_char());
      end else if (pick < 90) begin
        line.push_back(CH_HASH);
      end else if (pick < 95) begin
        line.push_back(CH_BSL);
        if ($urandom_range(0, 1)) begin
          line.push_back(CH_X);
          line.push_back(hex_char());
        end
        line.push_back(8'($urandom_range(0, 255)));
      end else begin
        line.push_back(8'($urandom_range(0, 255)));
      end
    end
    line.push_back(CH_NUL);
    foreach (line[i]) send_byte(line[i]);
    sent += line.size();
  endtask

  // ------------------------------------------------------------------ tests

  // reset options: octal modulo 256, octal flush, mixed-case hex,
  // bad escape on the line end byte
  task automatic test_escapes_directed();
    send_line("\\777\\0z\\xAf");
    send_line("\\");
  endtask

  // both options on: adjacent commas, closing quote then a new arg,
  // bad escape then skip, missing quote, comment
  task automatic test_separators_directed();
    write_reg(CFG_COMMENT, 1'b1);
    write_reg(CFG_COMMA, 1'b1);
    send_line(",,\"a\"b\\q");
    send_line(" \"\\t");
    send_line("#");
  endtask

  task automatic test_random_lines();
    int sent;
    for (int s = 0; s < 4; s++) begin
      write_reg(CFG_COMMENT, (s == 1 || s == 2));
      write_reg(CFG_COMMA, (s == 1 || s == 3));
      sent = 0;
      while (sent < 18) send_random_line(sent);
    end
  endtask

  task automatic test_full_rate();
    int sent;
    settle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    sent = 0;
    while (sent < 15) send_random_line(sent);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver holds off while lines keep coming, so the queue fills
  task automatic test_backpressure();
    int sent;
    settle();
    tx_idle_on = 1'b0;
    hold_until = cycle + 150;
    sent = 0;
    while (sent < 25) send_random_line(sent);
    settle();
    tx_idle_on = 1'b1;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_COMMENT;
    cfg_data = 1'b0;
    cycle = 0;
    beats_in = 0;
    errors = 0;
    hold_until = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    tk_phase = PH_BETWEEN;
    tk_quoted = 1'b0;
    tk_esc = 8'h00;
    tk_digits = 2'd0;
    opt_comment = 1'b0;
    opt_comma = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_escapes_directed();
    test_separators_directed();
    test_random_lines();
    test_full_rate();
    test_backpressure();

    settle();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("argv_tokenizer_with_escapes_unit_tb passed");
    end else begin
      $display("argv_tokenizer_with_escapes_unit_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/atok_pkg.sv
sv/atok_parse.sv
sv/atok_fifo.sv
sv/argv_tokenizer_with_escapes_unit.sv
verif/argv_tokenizer_with_escapes_unit_tb.sv
